// ===== rtl/cascaded_biquad_lowpass_assert.svh =====
// Assertion macros shared by the cascaded biquad lowpass RTL.
`ifndef CASCADED_BIQUAD_LOWPASS_ASSERT_SVH
`define CASCADED_BIQUAD_LOWPASS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbq_pkg.sv =====
// Package: widths, types and rounding helpers of the cascaded biquad lowpass.
`default_nettype none

package cbq_pkg;

  localparam int MaxStages  = 5;
  localparam int SampleW    = 16;
  localparam int FracBits   = 8;
  localparam int SigW       = SampleW + FracBits;  // Q.8 stage signal
  localparam int CoefW      = 18;                  // Q2.16
  localparam int CoefFrac   = 16;
  localparam int CoefRegW   = 3 * CoefW;
  localparam int SumW       = SigW + 2;            // x + 2*x1 + x2
  localparam int ProdW      = CoefW + SumW;
  localparam int AccW       = ProdW + 2;
  localparam int RndW       = AccW - CoefFrac;
  localparam int OutRndW    = SigW + 1 - FracBits;
  localparam int HistDepth  = MaxStages + 1;       // entry 0: stage 0 input history
  localparam int HistAddrW  = $clog2(HistDepth);
  localparam int HistW      = 2 * SigW;            // {h1, h2}
  localparam int StageCntW  = 3;
  localparam int CfgIdxW    = 3;

  typedef logic signed [SigW-1:0]     sig_t;
  typedef logic signed [SampleW-1:0]  smp_t;
  typedef logic signed [CoefW-1:0]    coef_t;
  typedef logic signed [SumW-1:0]     sum_t;
  typedef logic signed [ProdW-1:0]    prod_t;
  typedef logic signed [AccW-1:0]     acc_t;
  typedef logic signed [RndW-1:0]     rnd_t;
  typedef logic signed [OutRndW-1:0]  ornd_t;
  typedef logic [HistAddrW-1:0]       hist_addr_t;
  typedef logic [HistW-1:0]           hist_t;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_SUB  = 2'd2;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] acc_op;
  } mac_ctl_t;

  typedef struct packed {
    logic       en;
    hist_addr_t addr;
    hist_t      data;
  } hist_wr_t;

  typedef struct packed {
    logic clip;
    sig_t y;
  } stage_res_t;

  typedef struct packed {
    logic clip;
    smp_t y;
  } out_res_t;

  localparam acc_t  StageHalf = acc_t'(1) <<< (CoefFrac - 1);
  localparam rnd_t  StageMax  = rnd_t'((1 << (SigW - 1)) - 1);
  localparam rnd_t  StageMin  = rnd_t'(-(1 << (SigW - 1)));
  localparam sig_t  OutHalf   = sig_t'(1) <<< (FracBits - 1);
  localparam ornd_t OutMax    = ornd_t'((1 << (SampleW - 1)) - 1);
  localparam ornd_t OutMin    = ornd_t'(-(1 << (SampleW - 1)));

  // Q.24 accumulator -> Q.8 stage output, round half up, saturate.
  function automatic stage_res_t round_sat_stage(input acc_t acc);
    acc_t       t;
    rnd_t       q;
    stage_res_t r;
    t = acc + StageHalf;
    q = rnd_t'(t >>> CoefFrac);
    r.clip = 1'b0;
    r.y    = sig_t'(q);
    if (q > StageMax) begin
      r.clip = 1'b1;
      r.y    = sig_t'(StageMax);
    end else if (q < StageMin) begin
      r.clip = 1'b1;
      r.y    = sig_t'(StageMin);
    end
    return r;
  endfunction

  // Q.8 stage output -> integer sample, round half up, saturate.
  function automatic out_res_t round_sat_out(input sig_t y);
    logic signed [SigW:0] t;
    ornd_t                q;
    out_res_t             r;
    t = (SigW+1)'(y) + (SigW+1)'(OutHalf);
    q = ornd_t'(t >>> FracBits);
    r.clip = 1'b0;
    r.y    = smp_t'(q);
    if (q > OutMax) begin
      r.clip = 1'b1;
      r.y    = smp_t'(OutMax);
    end else if (q < OutMin) begin
      r.clip = 1'b1;
      r.y    = smp_t'(OutMin);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cascaded_biquad_lowpass.sv =====
// Top level: cascaded direct-form-I biquad lowpass with sequencer and config registers.
//
// Usage:
//   Input channel (in_valid / in_stall / in_cmd / in_sample): one transaction per
//   sample. in_cmd = 0 filters in_sample through stage_count biquads; in_cmd = 1
//   presets every history (input and all five stage outputs) to in_sample and
//   echoes it with out_clipped = 0.
//   Result channel (out_valid / out_stall / out_filtered / out_clipped): one
//   transaction per input transaction, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata): index 0 is
//   stage_count, 1..5 the packed {b2, b1, a0} Q2.16 coefficients of stages 0..4.
//   cfg_ready is always high; write only while no sample is in flight.
// Sequencing:
//   A filter sample passes through the active stages in turn from acceptance to
//   the result register: each stage is one history read plus three products on
//   the single shared multiplier and a write-back. A preset makes one write per
//   history entry. One sample is in work at a time; in_stall is high from
//   acceptance until the result is loaded into the output register, so the next
//   sample can be taken while a result waits out a stall.
// Reset (rst_n low, synchronous): stage_count = 1, coefficients 0, histories 0,
//   no result pending.
`default_nettype none

`include "cascaded_biquad_lowpass_assert.svh"

module cascaded_biquad_lowpass
  import cbq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input samples
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_cmd,
  input  wire logic signed [15:0]   in_sample,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [15:0]        out_filtered,
  output logic                      out_clipped,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CoefRegW-1:0]  cfg_wdata
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XH   = 4'd1;  // stage 0 input history arrives
  localparam logic [3:0] S_YH   = 4'd2;  // stage output history arrives
  localparam logic [3:0] S_M0   = 4'd3;  // a0 * (x + 2x1 + x2)
  localparam logic [3:0] S_M1   = 4'd4;  // b1 * y1
  localparam logic [3:0] S_M2   = 4'd5;  // b2 * y2
  localparam logic [3:0] S_M3   = 4'd6;  // last subtract
  localparam logic [3:0] S_WB   = 4'd7;  // round, write back, next stage
  localparam logic [3:0] S_PRE  = 4'd8;  // preset sweep
  localparam logic [3:0] S_FIN  = 4'd9;  // load result register

  // config register indexes
  localparam logic [CfgIdxW-1:0] CFG_STAGE_COUNT = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_COEF_FIRST  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_COEF_LAST   = CfgIdxW'(MaxStages);

  localparam logic [StageCntW-1:0] StageMaxCnt = StageCntW'(MaxStages);
  localparam hist_addr_t           HistLast    = hist_addr_t'(HistDepth - 1);

  // config registers
  logic [StageCntW-1:0] stage_count_r;
  logic [CoefRegW-1:0]  coef_r [MaxStages];

  // sequencer and datapath registers
  logic [3:0]           state_r,   state_nxt;
  logic [StageCntW-1:0] stage_r,   stage_nxt;
  logic [StageCntW-1:0] n_r,       n_nxt;
  logic                 preset_r,  preset_nxt;
  logic                 clip_r,    clip_nxt;
  hist_addr_t           pre_cnt_r, pre_cnt_nxt;
  smp_t                 smp_r,     smp_nxt;
  sig_t                 x_r,       x_nxt;
  sig_t                 x1_r,      x1_nxt;
  sig_t                 x2_r,      x2_nxt;
  sig_t                 y1_r,      y1_nxt;
  sig_t                 y2_r,      y2_nxt;
  logic                 out_valid_r, out_valid_nxt;
  smp_t                 out_filt_r,  out_filt_nxt;
  logic                 out_clip_r,  out_clip_nxt;

  logic                 in_take;
  logic [StageCntW-1:0] n_clamped;
  logic [StageCntW-1:0] stage_inc;
  logic [CoefRegW-1:0]  coef_sel;
  coef_t                a0, b1, b2;
  sum_t                 xsum;
  sig_t                 smp_q8;
  mac_ctl_t             mac_ctl;
  coef_t                mul_a;
  sum_t                 mul_b;
  stage_res_t           stage_res;
  out_res_t             fin_res;
  hist_wr_t             hist_wr;
  logic                 hist_rd_en;
  hist_addr_t           hist_rd_addr;
  logic [HistW-1:0]     hist_rd_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // stage count 0 acts as 1, above the cascade depth as the full depth
  always_comb begin
    priority if (stage_count_r == '0) begin
      n_clamped = StageCntW'(1);
    end else if (stage_count_r > StageMaxCnt) begin
      n_clamped = StageMaxCnt;
    end else begin
      n_clamped = stage_count_r;
    end
  end

  assign coef_sel  = coef_r[stage_r];
  assign a0        = coef_t'(coef_sel[CoefW-1:0]);
  assign b1        = coef_t'(coef_sel[2*CoefW-1:CoefW]);
  assign b2        = coef_t'(coef_sel[3*CoefW-1:2*CoefW]);
  assign xsum      = sum_t'(x_r) + (sum_t'(x1_r) <<< 1) + sum_t'(x2_r);
  assign smp_q8    = sig_t'(smp_r) <<< FracBits;
  assign stage_inc = stage_r + StageCntW'(1);
  assign fin_res   = round_sat_out(x_r);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_count_r <= StageCntW'(1);
      for (int i = 0; i < MaxStages; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_STAGE_COUNT) begin
        stage_count_r <= cfg_wdata[StageCntW-1:0];
      end else if (cfg_index <= CFG_COEF_LAST) begin
        coef_r[cfg_index - CFG_COEF_FIRST] <= cfg_wdata;
      end
    end
  end

  // multiplier operand select, one product per cycle
  always_comb begin
    mac_ctl.mul_en = 1'b0;
    mac_ctl.acc_op = ACC_HOLD;
    mul_a          = a0;
    mul_b          = xsum;
    unique case (state_r)
      S_M0: begin
        mac_ctl.mul_en = 1'b1;
      end
      S_M1: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = ACC_LOAD;
        mul_a          = b1;
        mul_b          = sum_t'(y1_r);
      end
      S_M2: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = ACC_SUB;
        mul_a          = b2;
        mul_b          = sum_t'(y2_r);
      end
      S_M3: begin
        mac_ctl.acc_op = ACC_SUB;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    n_nxt         = n_r;
    preset_nxt    = preset_r;
    clip_nxt      = clip_r;
    pre_cnt_nxt   = pre_cnt_r;
    smp_nxt       = smp_r;
    x_nxt         = x_r;
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    out_valid_nxt = out_valid_r;
    out_filt_nxt  = out_filt_r;
    out_clip_nxt  = out_clip_r;
    hist_wr.en    = 1'b0;
    hist_wr.addr  = '0;
    hist_wr.data  = '0;
    hist_rd_en    = 1'b0;
    hist_rd_addr  = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          smp_nxt     = in_sample;
          n_nxt       = n_clamped;
          stage_nxt   = '0;
          clip_nxt    = 1'b0;
          pre_cnt_nxt = '0;
          preset_nxt  = in_cmd;
          if (in_cmd) begin
            state_nxt = S_PRE;
          end else begin
            hist_rd_en   = 1'b1;
            hist_rd_addr = '0;
            state_nxt    = S_XH;
          end
        end
      end
      S_XH: begin
        x_nxt        = smp_q8;
        x1_nxt       = sig_t'(hist_rd_data[HistW-1:SigW]);
        x2_nxt       = sig_t'(hist_rd_data[SigW-1:0]);
        // input history shifts now; the old value is held in x1/x2
        hist_wr.en   = 1'b1;
        hist_wr.addr = '0;
        hist_wr.data = {smp_q8, hist_rd_data[HistW-1:SigW]};
        hist_rd_en   = 1'b1;
        hist_rd_addr = hist_addr_t'(1);
        state_nxt    = S_YH;
      end
      S_YH: begin
        y1_nxt    = sig_t'(hist_rd_data[HistW-1:SigW]);
        y2_nxt    = sig_t'(hist_rd_data[SigW-1:0]);
        state_nxt = S_M0;
      end
      S_M0: state_nxt = S_M1;
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_M3;
      S_M3: state_nxt = S_WB;
      S_WB: begin
        hist_wr.en   = 1'b1;
        hist_wr.addr = hist_addr_t'(stage_inc);
        hist_wr.data = {stage_res.y, y1_r};
        clip_nxt     = clip_r | stage_res.clip;
        // this stage's output and old history feed the next stage
        x_nxt        = stage_res.y;
        x1_nxt       = y1_r;
        x2_nxt       = y2_r;
        if (stage_inc < n_r) begin
          stage_nxt    = stage_inc;
          hist_rd_en   = 1'b1;
          hist_rd_addr = hist_addr_t'(stage_inc) + hist_addr_t'(1);
          state_nxt    = S_YH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PRE: begin
        hist_wr.en   = 1'b1;
        hist_wr.addr = pre_cnt_r;
        hist_wr.data = {smp_q8, smp_q8};
        if (pre_cnt_r == HistLast) begin
          state_nxt = S_FIN;
        end else begin
          pre_cnt_nxt = pre_cnt_r + hist_addr_t'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (preset_r) begin
            out_filt_nxt = smp_r;
            out_clip_nxt = 1'b0;
          end else begin
            out_filt_nxt = fin_res.y;
            out_clip_nxt = clip_r | fin_res.clip;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r    <= stage_nxt;
    n_r        <= n_nxt;
    preset_r   <= preset_nxt;
    clip_r     <= clip_nxt;
    pre_cnt_r  <= pre_cnt_nxt;
    smp_r      <= smp_nxt;
    x_r        <= x_nxt;
    x1_r       <= x1_nxt;
    x2_r       <= x2_nxt;
    y1_r       <= y1_nxt;
    y2_r       <= y2_nxt;
    out_filt_r <= out_filt_nxt;
    out_clip_r <= out_clip_nxt;
  end

  cbq_hist_mem u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (hist_wr),
    .rd_en   (hist_rd_en),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

  cbq_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .res   (stage_res)
  );

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filt_r;
  assign out_clipped  = out_clip_r;

  `CBQ_ASSERT_NEXT(a_take_goes_busy, in_take, state_r != S_IDLE, "accepted transaction left the sequencer idle")
  `CBQ_ASSERT_NOW(a_result_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN, "result loaded outside the final state")
  `CBQ_ASSERT_NOW(a_stage_in_range, state_r == S_WB, stage_r < n_r, "stage index beyond active stage count")

endmodule

`default_nettype wire

// ===== rtl/cbq_hist_mem.sv =====
// History memory: one {h1, h2} entry for the stage 0 input and one per stage output, registered read.
`default_nettype none

`include "cascaded_biquad_lowpass_assert.svh"

module cbq_hist_mem
  import cbq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hist_wr_t   wr,
  input  wire logic       rd_en,
  input  wire hist_addr_t rd_addr,
  output logic [HistW-1:0] rd_data
);

  hist_t                 mem [HistDepth];
  logic [HistDepth-1:0]  vld_r;
  logic [HistDepth-1:0]  vld_nxt;
  hist_t                 rd_data_r;
  logic                  rd_vld_r;
  logic                  rd_vld_nxt;

  // entries never written read as zero (reset history)
  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.addr] = 1'b1;
    end
    rd_vld_nxt = rd_vld_r;
    if (rd_en) begin
      rd_vld_nxt = vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

  `CBQ_ASSERT_NOW(a_no_rw_collide, wr.en && rd_en, wr.addr != rd_addr, "history read and write hit the same entry")

endmodule

`default_nettype wire

// ===== rtl/cbq_mac.sv =====
// Shared multiply-accumulate unit with stage output rounding.
`default_nettype none

module cbq_mac
  import cbq_pkg::*;
(
  input  wire logic     clk,
  input  wire mac_ctl_t ctl,
  input  wire coef_t    mul_a,
  input  wire sum_t     mul_b,
  output stage_res_t    res
);

  prod_t prod_r;
  prod_t prod_nxt;
  acc_t  acc_r;
  acc_t  acc_nxt;

  always_comb begin
    prod_nxt = prod_r;
    if (ctl.mul_en) begin
      prod_nxt = prod_t'(mul_a) * prod_t'(mul_b);
    end
    unique case (ctl.acc_op)
      ACC_LOAD: acc_nxt = acc_t'(prod_r);
      ACC_SUB:  acc_nxt = acc_r - acc_t'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign res = round_sat_stage(acc_r);

endmodule

`default_nettype wire

// ===== bench/tb_cascaded_biquad_lowpass.sv =====
// Self-checking regression bench for the cascaded biquad lowpass filter.
`timescale 1ns / 1ps

module tb_cascaded_biquad_lowpass;
  import cbq_pkg::*;

  // Register map of the config channel; indexes 6 and 7 decode to nothing.
  typedef enum logic [CfgIdxW-1:0] {
    REG_STAGE_COUNT = 3'd0,
    REG_COEF0       = 3'd1,
    REG_COEF1       = 3'd2,
    REG_COEF2       = 3'd3,
    REG_COEF3       = 3'd4,
    REG_COEF4       = 3'd5,
    REG_SPARE6      = 3'd6,
    REG_SPARE7      = 3'd7
  } reg_index_e;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_PRESET = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [SampleW-1:0] filtered;
    logic                      clipped;
  } result_t;

  // One row of the directed table: either a register write or a sample.
  // known = 1 means the expected result is typed in the row itself.
  typedef struct packed {
    logic                      is_cfg;
    reg_index_e                idx;
    logic [CoefRegW-1:0]       wdata;
    cmd_e                      cmd;
    logic signed [SampleW-1:0] smp;
    logic                      known;
    logic signed [SampleW-1:0] exp_y;
    logic                      exp_clip;
  } dir_row_t;

  localparam int WatchdogLimit = 2000;   // cycles with no transaction on any channel
  localparam int TargetItems   = 700;
  localparam int DrainCycles   = 60;     // longer than one five-stage sample

  // Q.8 stage range and output sample range
  localparam longint SigHi = (longint'(1) << (SigW - 1)) - 1;
  localparam longint SigLo = -(longint'(1) << (SigW - 1));
  localparam longint SmpHi = (longint'(1) << (SampleW - 1)) - 1;
  localparam longint SmpLo = -(longint'(1) << (SampleW - 1));

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_cmd = 1'b0;
  logic signed [SampleW-1:0]  in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SampleW-1:0]  out_filtered;
  logic                       out_clipped;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CfgIdxW-1:0]         cfg_index = '0;
  logic [CoefRegW-1:0]        cfg_wdata = '0;

  cascaded_biquad_lowpass DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_clipped  (out_clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Filter model: shadow config plus the full history of every stage.
  // ---------------------------------------------------------------------------
  logic [StageCntW-1:0]      shadow_stage_cnt;
  logic [CoefRegW-1:0]       shadow_coef [MaxStages];
  logic signed [SampleW-1:0] sample_hist [2];            // x1, x2 of stage 0
  logic signed [SigW-1:0]    stage_hist  [2*MaxStages];  // y1, y2 per stage, Q.8

  result_t pending_results [$];   // expected results, oldest first

  int  errors      = 0;
  int  n_items     = 0;
  int  n_presets   = 0;
  int  n_clipped   = 0;
  int  n_writes    = 0;
  int  n_phases    = 0;
  bit  gaps_on     = 1'b1;        // sender inserts idle cycles
  bit  stalls_on   = 1'b1;        // receiver asserts out_stall

  function automatic void clear_filter_model();
    shadow_stage_cnt = 3'd1;
    for (int i = 0; i < MaxStages; i++) shadow_coef[i] = '0;
    sample_hist[0] = '0;
    sample_hist[1] = '0;
    for (int i = 0; i < 2*MaxStages; i++) stage_hist[i] = '0;
  endfunction

  function automatic void shadow_write(reg_index_e idx, logic [CoefRegW-1:0] data);
    if (idx == REG_STAGE_COUNT)
      shadow_stage_cnt = data[StageCntW-1:0];
    else if (idx <= REG_COEF4)
      shadow_coef[idx - REG_COEF0] = data;
    // spare indexes change nothing
  endfunction

  // Runs one transaction through the cascade and advances the histories.
  function automatic result_t lowpass_predict(cmd_e cmd, logic signed [SampleW-1:0] s);
    result_t           r;
    longint            y_new [MaxStages];
    longint            a0, b1, b2, x, x1, x2, y1, y2, acc, q;
    logic signed [CoefW-1:0] ca, cb, cc;
    int                n;
    bit                clip;
    clip = 1'b0;
    if (cmd == CMD_PRESET) begin
      // preset loads every stage, active or not, and echoes the value
      sample_hist[0] = s;
      sample_hist[1] = s;
      for (int i = 0; i < 2*MaxStages; i++) begin
        x = s;
        stage_hist[i] = x * 256;
      end
      r.filtered = s;
      r.clipped  = 1'b0;
      return r;
    end
    n = shadow_stage_cnt;
    if (n < 1) n = 1;                     // a count of zero behaves as one
    if (n > MaxStages) n = MaxStages;     // six and seven behave as five
    for (int i = 0; i < n; i++) begin
      ca = shadow_coef[i][CoefW-1:0];
      cb = shadow_coef[i][2*CoefW-1:CoefW];
      cc = shadow_coef[i][3*CoefW-1:2*CoefW];
      a0 = ca;
      b1 = cb;
      b2 = cc;
      if (i == 0) begin
        x  = s;
        x  = x * 256;
        x1 = sample_hist[0];
        x1 = x1 * 256;
        x2 = sample_hist[1];
        x2 = x2 * 256;
      end else begin
        // stage input history is the previous stage's output history
        x  = y_new[i-1];
        x1 = stage_hist[2*(i-1)];
        x2 = stage_hist[2*(i-1)+1];
      end
      y1  = stage_hist[2*i];
      y2  = stage_hist[2*i+1];
      acc = a0 * (x + 2*x1 + x2) - b1 * y1 - b2 * y2;
      q   = (acc + 32768) >>> CoefFrac;   // round half up to Q.8
      if (q > SigHi) begin
        q = SigHi;
        clip = 1'b1;
      end else if (q < SigLo) begin
        q = SigLo;
        clip = 1'b1;
      end
      y_new[i] = q;
    end
    // all stages used the old histories; now shift each active one
    sample_hist[1] = sample_hist[0];
    sample_hist[0] = s;
    for (int i = 0; i < n; i++) begin
      stage_hist[2*i+1] = stage_hist[2*i];
      stage_hist[2*i]   = y_new[i][SigW-1:0];
    end
    q = (y_new[n-1] + 128) >>> FracBits;
    if (q > SmpHi) begin
      q = SmpHi;
      clip = 1'b1;
    end else if (q < SmpLo) begin
      q = SmpLo;
      clip = 1'b1;
    end
    r.filtered = q[SampleW-1:0];
    r.clipped  = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CoefRegW-1:0] pack_coef(int a0, int b1, int b2);
    logic [CoefW-1:0] f0, f1, f2;
    f0 = a0[CoefW-1:0];
    f1 = b1[CoefW-1:0];
    f2 = b2[CoefW-1:0];
    return {f2, f1, f0};
  endfunction

  // Butterworth sections at fc/fs = 0.1, 0.25 and 0.02, Q2.16
  function automatic logic [CoefRegW-1:0] lowpass_coef(int k, int a0_nudge);
    case (k)
      0:       return pack_coef(4421 + a0_nudge, -74907, 27053);
      1:       return pack_coef(19195 + a0_nudge, 0, 11244);
      default: return pack_coef(237 + a0_nudge, -119452, 54866);
    endcase
  endfunction

  function automatic logic [CoefRegW-1:0] random_bits54();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[CoefRegW-1:0];
  endfunction

  function automatic logic [CoefRegW-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return lowpass_coef($urandom_range(0, 2), 0);
    if (r < 75) return lowpass_coef($urandom_range(0, 2), $urandom_range(0, 4000) - 2000);
    return random_bits54();   // mostly unstable, drives saturation
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 9) return $urandom_range(0, 2000) - 1000;
    case ($urandom_range(0, 3))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // in_valid stays high after an accepted transaction so that back-to-back
  // samples never lower and raise it in the same time step.
  task automatic send_sample(cmd_e cmd, logic signed [SampleW-1:0] smp, bit known,
                             logic signed [SampleW-1:0] exp_y, bit exp_clip);
    int      gap;
    result_t want;
    gap = pick_gap(gaps_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = lowpass_predict(cmd, smp);
    if (known) begin
      want.filtered = exp_y;
      want.clipped  = exp_clip;
    end
    pending_results.push_back(want);
    n_items++;
    if (cmd == CMD_PRESET) n_presets++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_e idx, logic [CoefRegW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_write(idx, data);
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, scoreboard, watchdog
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap(stalls_on);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected (filtered %0d, clipped %0d)",
                 $time, out_filtered, out_clipped);
      end else begin
        want = pending_results.pop_front();
        if (out_clipped) n_clipped++;
        if (out_filtered !== want.filtered) begin
          errors++;
          if (errors <= 20)
            $display("%0t: filtered mismatch, expected %0d, got %0d",
                     $time, want.filtered, out_filtered);
        end
        if (out_clipped !== want.clipped) begin
          errors++;
          if (errors <= 20)
            $display("%0t: clipped mismatch, expected %0d, got %0d",
                     $time, want.clipped, out_clipped);
        end
      end
    end
  end

  // Any transaction on any channel restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WatchdogLimit, pending_results.size());
        $display("cascaded_biquad_lowpass regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: reset state, saturation on both rails, presets, extreme
  // coefficients, out-of-range stage counts and writes to unused indexes.
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [$];

  task automatic build_directed_rows();
    // zero coefficients after reset: everything filters to zero
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd1234,
                              1'b1, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, -16'sd32768,
                              1'b1, 16'sd0, 1'b0});
    // presets echo the value on both rails
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_PRESET, 16'sd32767,
                              1'b1, 16'sd32767, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_PRESET, -16'sd32768,
                              1'b1, -16'sd32768, 1'b0});
    // a0 = 1.0, no feedback: one stage gives x + 2*x1 + x2
    directed_rows.push_back('{1'b1, REG_COEF0, pack_coef(65536, 0, 0), CMD_FILTER,
                              16'sd0, 1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_PRESET, 16'sd0,
                              1'b1, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd100,
                              1'b1, 16'sd100, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd100,
                              1'b1, 16'sd300, 1'b0});
    // sums past full scale saturate high, then low
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd32767,
                              1'b1, 16'sd32767, 1'b1});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, -16'sd32768,
                              1'b1, 16'sd32767, 1'b1});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, -16'sd32768,
                              1'b1, -16'sd32768, 1'b1});
    // a count of zero runs a single stage
    directed_rows.push_back('{1'b1, REG_STAGE_COUNT, 54'd0, CMD_FILTER, 16'sd0,
                              1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd0,
                              1'b0, 16'sd0, 1'b0});
    // most negative and most positive Q2.16 values in every field
    directed_rows.push_back('{1'b1, REG_COEF0, pack_coef(-131072, -131072, -131072),
                              CMD_FILTER, 16'sd0, 1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b1, REG_COEF1, pack_coef(131071, 131071, 131071),
                              CMD_FILTER, 16'sd0, 1'b0, 16'sd0, 1'b0});
    // seven behaves as five
    directed_rows.push_back('{1'b1, REG_STAGE_COUNT, 54'd7, CMD_FILTER, 16'sd0,
                              1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd32767,
                              1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, -16'sd1,
                              1'b0, 16'sd0, 1'b0});
    // writes to unused indexes must not disturb anything
    directed_rows.push_back('{1'b1, REG_SPARE6, {CoefRegW{1'b1}}, CMD_FILTER, 16'sd0,
                              1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b1, REG_SPARE7, {CoefRegW{1'b1}}, CMD_FILTER, 16'sd0,
                              1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd12345,
                              1'b0, 16'sd0, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_PRESET, -16'sd1,
                              1'b1, -16'sd1, 1'b0});
    directed_rows.push_back('{1'b0, REG_STAGE_COUNT, '0, CMD_FILTER, 16'sd0,
                              1'b0, 16'sd0, 1'b0});
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                  phase_len;
    int                  cnt;
    logic [CoefRegW-1:0] cnt_word;
    dir_row_t            row;

    clear_filter_model();
    build_directed_rows();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: config rows only ever land on an idle filter
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.idx, row.wdata);
      end else begin
        send_sample(row.cmd, row.smp, row.known, row.exp_y, row.exp_clip);
      end
    end

    // random part: each phase reprograms the whole cascade, then streams
    // samples with occasional presets. Early phases pin the count extremes.
    while (n_items < TargetItems) begin
      wait_idle();
      case (n_phases)
        0:       cnt = 5;
        1:       cnt = 1;
        2:       cnt = 0;
        3:       cnt = 7;
        default: cnt = $urandom_range(0, 7);
      endcase
      cnt_word = random_bits54();
      cnt_word[StageCntW-1:0] = cnt[StageCntW-1:0];
      write_reg(REG_STAGE_COUNT, cnt_word);
      for (int st = 0; st < MaxStages; st++)
        write_reg(reg_index_e'(REG_COEF0 + st), n_phases == 0 ? lowpass_coef(st % 3, 0)
                                                                  : pick_coef());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, random_bits54());
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      phase_len = $urandom_range(30, 80);
      for (int j = 0; j < phase_len; j++) begin
        // in every third phase the sender holds off mid-phase until the filter has drained
        if (j == phase_len / 2 && n_phases % 3 == 0) wait_idle();
        send_sample($urandom_range(0, 99) < 6 ? CMD_PRESET : CMD_FILTER, pick_sample(),
                    1'b0, 16'sd0, 1'b0);
      end
      n_phases++;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d samples (%0d presets, %0d clipped results) and %0d register writes",
             n_items, n_presets, n_clipped, n_writes);
    $display("over %0d random phases with stage counts 0..7 and mixed idle/stall pressure.",
             n_phases);
    if (errors == 0) begin
      $display("cascaded_biquad_lowpass regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("cascaded_biquad_lowpass regression: fail");
    end
    $finish;
  end

endmodule
